### rtl/pdl_pkg.sv
// ============================================================================
// pdl_pkg: shared definitions for the prime divisor lister
// Value width, result limit, sequencer states and the divider request and
// response bundles.
// ============================================================================
package pdl_pkg;

    localparam int VALUE_BITS  = 31;
    localparam int MAX_RESULTS = 9;
    localparam int FIRST_PRIME = 2;

    // Result counter must hold MAX_RESULTS itself.
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    // The divider retires one quotient bit per cycle.
    localparam int DIV_STEPS = VALUE_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]      count_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NLAUNCH,
        ST_NWAIT,
        ST_PCHK,
        ST_PLAUNCH,
        ST_PWAIT,
        ST_PUSH,
        ST_AFTER,
        ST_NEXT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic   start;
        value_t dividend;
        value_t divisor;
    } div_req_t;

    typedef struct packed {
        logic   done;
        value_t quotient;
        value_t remainder;
    } div_rsp_t;

endpackage

### rtl/pdl_if.sv
// ============================================================================
// pdl_if: handshake channels of the prime divisor lister
// Input channel carries one number per transaction; output channel carries
// one prime divisor with its flags per transaction.
// ============================================================================
interface pdl_in_if import pdl_pkg::*; ();

    logic   valid;
    logic   ready;
    value_t number_in;

    modport source (output valid, output number_in, input ready);
    modport sink   (input valid, input number_in, output ready);

endinterface

interface pdl_out_if import pdl_pkg::*; ();

    logic   valid;
    logic   ready;
    value_t prime_divisor;
    logic   none_found;
    logic   is_last;

    modport source (output valid, output prime_divisor, output none_found,
                    output is_last, input ready);
    modport sink   (input valid, input prime_divisor, input none_found,
                    input is_last, output ready);

endinterface

### rtl/pdl_div.sv
// ============================================================================
// pdl_div: shared restoring divider
// Produces quotient and remainder of two unsigned values, one bit per cycle.
// ============================================================================
module pdl_div import pdl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    value_t                rem_reg, rem_next;
    value_t                quo_reg, quo_next;
    value_t                dsr_reg, dsr_next;

    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[VALUE_BITS-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // Keep the trial difference only when it did not borrow.
            rem_next = diff[VALUE_BITS] ? shifted[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
            quo_next = {quo_reg[VALUE_BITS-2:0], ~diff[VALUE_BITS]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### rtl/pdl_seq.sv
// ============================================================================
// pdl_seq: trial division sequencer
// Steps the candidate divisor, runs primality checks through the shared
// divider and holds one found divisor back so the last one can be flagged.
// ============================================================================
module pdl_seq import pdl_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    pdl_in_if.sink         number,
    pdl_out_if.source      result,
    output div_req_t       div_req,
    input  div_rsp_t       div_rsp
);

    state_t  state_reg, state_next;

    value_t  n_reg, n_next;
    value_t  i_reg, i_next;
    value_t  q_reg, q_next;
    value_t  m_reg, m_next;
    value_t  d_reg, d_next;
    logic    which_reg, which_next;
    count_t  cnt_reg, cnt_next;
    logic    pend_valid_reg, pend_valid_next;
    value_t  pend_reg, pend_next;

    logic    out_valid_reg, out_valid_next;
    value_t  out_div_reg, out_div_next;
    logic    out_none_reg, out_none_next;
    logic    out_last_reg, out_last_next;

    logic    out_free;
    logic    room_left;

    assign out_free  = !out_valid_reg || result.ready;
    assign room_left = cnt_reg < CNT_W'(MAX_RESULTS);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (number.valid)
                begin
                    state_next = ST_NLAUNCH;
                end
            end
            ST_NLAUNCH:
            begin
                state_next = ST_NWAIT;
            end
            ST_NWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (i_reg > div_rsp.quotient)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (div_rsp.remainder != '0)
                    begin
                        state_next = ST_NEXT;
                    end
                    else
                    begin
                        state_next = ST_PCHK;
                    end
                end
            end
            ST_PCHK:
            begin
                state_next = (m_reg < VALUE_BITS'(FIRST_PRIME)) ? ST_AFTER : ST_PLAUNCH;
            end
            ST_PLAUNCH:
            begin
                state_next = ST_PWAIT;
            end
            ST_PWAIT:
            begin
                if (div_rsp.done)
                begin
                    if (d_reg > div_rsp.quotient)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if (div_rsp.remainder == '0)
                    begin
                        state_next = ST_AFTER;
                    end
                    else
                    begin
                        state_next = ST_PLAUNCH;
                    end
                end
            end
            ST_PUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_AFTER;
                end
            end
            ST_AFTER:
            begin
                if (!which_reg && room_left && q_reg != i_reg)
                begin
                    state_next = ST_PCHK;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                state_next = room_left ? ST_NLAUNCH : ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        n_next          = n_reg;
        i_next          = i_reg;
        q_next          = q_reg;
        m_next          = m_reg;
        d_next          = d_reg;
        which_next      = which_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_div_next    = out_div_reg;
        out_none_next   = out_none_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        number.ready    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = n_reg;
        div_req.divisor  = i_reg;

        case (state_reg)
            ST_IDLE:
            begin
                number.ready = 1'b1;
                if (number.valid)
                begin
                    n_next          = number.number_in;
                    i_next          = VALUE_BITS'(1);
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_NLAUNCH:
            begin
                div_req.start = 1'b1;
            end
            ST_NWAIT:
            begin
                if (div_rsp.done)
                begin
                    q_next     = div_rsp.quotient;
                    m_next     = i_reg;
                    which_next = 1'b0;
                end
            end
            ST_PCHK:
            begin
                d_next = VALUE_BITS'(FIRST_PRIME);
            end
            ST_PLAUNCH:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = m_reg;
                div_req.divisor  = d_reg;
            end
            ST_PWAIT:
            begin
                if (div_rsp.done)
                begin
                    d_next = d_reg + 1'b1;
                end
            end
            ST_PUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    // The held divisor is not the last one: release it.
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_div_next   = pend_reg;
                        out_none_next  = 1'b0;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = m_reg;
                    cnt_next        = cnt_reg + 1'b1;
                end
            end
            ST_AFTER:
            begin
                if (!which_reg && room_left && q_reg != i_reg)
                begin
                    which_next = 1'b1;
                    m_next     = q_reg;
                end
            end
            ST_NEXT:
            begin
                i_next = i_reg + 1'b1;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_none_next   = !pend_valid_reg;
                    out_div_next    = pend_valid_reg ? pend_reg : '0;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            which_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
            which_reg      <= which_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        q_reg        <= q_next;
        m_reg        <= m_next;
        d_reg        <= d_next;
        pend_reg     <= pend_next;
        out_div_reg  <= out_div_next;
        out_none_reg <= out_none_next;
        out_last_reg <= out_last_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.prime_divisor = out_div_reg;
    assign result.none_found    = out_none_reg;
    assign result.is_last       = out_last_reg;

endmodule

### rtl/prime_divisor_lister_top.sv
// ============================================================================
// prime_divisor_lister_top: prime divisors of one number by trial division
// Lists the prime divisors of each input number through one shared divider.
// ============================================================================
// Work: every division goes through the shared divider. A number n costs
// about sqrt(n) divisions for the candidate sweep plus up to sqrt(d)
// divisions for each divisor d found; a 31-bit prime needs about
// 2 x 46341 divisions.
// Throughput: one number at a time; the input is ready only while idle.
// Reset: rst_n clears the sequencer, the held divisor and the output register.
// ============================================================================
module prime_divisor_lister_top import pdl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pdl_in_if.sink     number,
    pdl_out_if.source  result
);

    // The sequencer owns the candidate sweep and the primality checks. Every
    // quotient and remainder it needs, including the bound test i <= n / i,
    // comes from the one divider below.
    div_req_t div_req;
    div_rsp_t div_rsp;

    pdl_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .number  (number),
        .result  (result),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // The shared divider retires one quotient bit per cycle and pulses done
    // for one cycle; its results stay stable until the next start.
    pdl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

### tb/tb_prime_divisor_lister_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_prime_divisor_lister_top: self-checking bench for the prime divisor lister
// Sends numbers through the input channel and predicts the prime divisor list
// of each one by trial division. Every output transaction is compared with the
// oldest prediction. The sender works in bursts and the receiver stalls.
// ============================================================================
module tb_prime_divisor_lister_top;
    import pdl_pkg::*;

    // The 31-bit prime at the top of the range is by far the slowest item;
    // small numbers finish quickly. The limit covers the worst item several times over.
    localparam longint CYCLE_LIMIT = 25_000_000;
    localparam int     DRAIN_CYCLES = 200;

    typedef struct {
        value_t value;
        bit     drain;  // wait until every listed divisor has come back
    } number_item_t;

    typedef struct {
        value_t divisor;
        bit     none;
        bit     last;
    } divisor_exp_t;

    logic clk;
    logic rst_n;

    pdl_in_if  number_if ();
    pdl_out_if result_if ();

    prime_divisor_lister_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_if),
        .result (result_if)
    );

    number_item_t pending_numbers[$];
    divisor_exp_t expected_divisors[$];

    int     error_count    = 0;
    int     accepted_count = 0;
    longint cycle_count    = 0;
    logic   in_taken;

    // Sender burst control and receiver stall pattern.
    int burst_left = 1;
    int gap_left   = 0;
    int ready_left = 0;
    bit ready_level = 1'b1;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // A value is prime when it is at least two and no d with d*d <= m
    // divides it. The bound is written as d <= m / d so it cannot overflow.
    function automatic bit value_is_prime(input longint unsigned m);
        longint unsigned d;
        if (m < FIRST_PRIME)
            return 1'b0;
        for (d = FIRST_PRIME; d <= m / d; d++)
            if (m % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // Sweep the candidate i upward from one while i*i <= n. For each divisor
    // emit i when it is prime, then n/i when that is prime and differs from i.
    // The list is capped at MAX_RESULTS entries and the final one is flagged.
    task automatic predict_prime_divisors(input value_t number);
        longint unsigned n;
        longint unsigned i;
        longint unsigned q;
        int              count;
        divisor_exp_t    found[$];
        divisor_exp_t    entry;
        n     = longint'(number);
        count = 0;
        entry.none = 1'b0;
        entry.last = 1'b0;
        for (i = 1; n != 0 && i <= n / i && count < MAX_RESULTS; i++)
        begin
            if (n % i == 0)
            begin
                q = n / i;
                if (value_is_prime(i))
                begin
                    entry.divisor = value_t'(i);
                    found.push_back(entry);
                    count++;
                end
                if (count < MAX_RESULTS && q != i && value_is_prime(q))
                begin
                    entry.divisor = value_t'(q);
                    found.push_back(entry);
                    count++;
                end
            end
        end
        // Zero and one have no prime divisor, so a single marker stands alone.
        if (count == 0)
        begin
            entry.divisor = '0;
            entry.none    = 1'b1;
            entry.last    = 1'b1;
            found.push_back(entry);
        end
        else
        begin
            found[count-1].last = 1'b1;
        end
        foreach (found[k])
            expected_divisors.push_back(found[k]);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Most random numbers stay small so the trial division finishes quickly.
    // Squares of primes and composites exercise the case where i equals n/i.
    function automatic value_t random_number();
        int     pick;
        value_t root;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return value_t'($urandom_range(0, 1023));
        if (pick < 85)
            return value_t'($urandom_range(0, 65535));
        if (pick < 94)
        begin
            root = value_t'($urandom_range(2, 255));
            return root * root;
        end
        return value_t'($urandom_range(0, 1));
    endfunction

    task automatic add_number(input value_t value, input bit drain);
        number_item_t item;
        item.value = value;
        item.drain = drain;
        pending_numbers.push_back(item);
    endtask

    task automatic fill_directed();
        // Zero and one: no prime divisor, a single none_found transaction.
        add_number(0, 1'b0);
        add_number(1, 1'b0);
        // Smallest primes and the square of two, where i and n/i coincide, then products of two primes.
        add_number(2, 1'b0);
        add_number(3, 1'b0);
        add_number(4, 1'b0);
        add_number(6, 1'b0);
        add_number(15, 1'b0);
        add_number(77, 1'b0);
        // Prime squares land exactly on the sweep bound i*i == n.
        add_number(9, 1'b0);
        add_number(49, 1'b0);
        add_number(121, 1'b0);
        // One below a square, and the product of two neighboring primes.
        add_number(120, 1'b0);
        add_number(143, 1'b0);
        add_number(97, 1'b0);
        add_number(1024, 1'b0);
        add_number(210, 1'b1);
        add_number(2310, 1'b0);
        add_number(30030, 1'b0);
        add_number(510510, 1'b0);
        add_number(9699690, 1'b0);
        add_number(65521, 1'b0);
        add_number(65536, 1'b0);
        // Product of the first nine primes fills the whole result list.
        add_number(223092870, 1'b1);
        // Largest value of the field, which is itself prime: slowest case.
        add_number({VALUE_BITS{1'b1}}, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: values change at the falling edge. The valid line stays
    // high across back-to-back transactions, with one assignment per edge.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        number_item_t item;
        logic         drive;
        if (!rst_n)
        begin
            number_if.valid <= 1'b0;
        end
        else if (!(number_if.valid && !in_taken))
        begin
            drive = 1'b0;
            if (number_if.valid)
            begin
                // The previous transaction went through; close the burst
                // when it runs out and schedule a gap before the next one.
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_numbers.size() > 0 &&
                     !(pending_numbers[0].drain && expected_divisors.size() > 0))
            begin
                item = pending_numbers.pop_front();
                number_if.number_in <= item.value;
                drive = 1'b1;
            end
            number_if.valid <= drive;
        end
    end

    // ------------------------------------------------------------------------
    // Output ready: runs of stall and no stall of random length, with an
    // occasional long stretch where the receiver never stalls.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (ready_left <= 0)
            begin
                case ($urandom_range(0, 7))
                    0:
                    begin
                        ready_level = 1'b1;
                        ready_left  = $urandom_range(100, 400);
                    end
                    1, 2:
                    begin
                        ready_level = 1'b0;
                        ready_left  = $urandom_range(1, 15);
                    end
                    default:
                    begin
                        ready_level = 1'b1;
                        ready_left  = $urandom_range(1, 40);
                    end
                endcase
            end
            ready_left--;
            result_if.ready <= ready_level;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: at the rising edge, predict for each accepted number and
    // compare each accepted result with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        divisor_exp_t want;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= number_if.valid && number_if.ready;
            if (number_if.valid && number_if.ready)
            begin
                predict_prime_divisors(number_if.number_in);
                accepted_count++;
            end
            if (result_if.valid && result_if.ready)
            begin
                if (expected_divisors.size() == 0)
                begin
                    $error("prime_divisor: no transaction expected, got %0d",
                           result_if.prime_divisor);
                    error_count++;
                end
                else
                begin
                    want = expected_divisors.pop_front();
                    if (result_if.prime_divisor !== want.divisor)
                    begin
                        $error("prime_divisor: expected %0d, got %0d",
                               want.divisor, result_if.prime_divisor);
                        error_count++;
                    end
                    if (result_if.none_found !== want.none)
                    begin
                        $error("none_found: expected %0d, got %0d",
                               want.none, result_if.none_found);
                        error_count++;
                    end
                    if (result_if.is_last !== want.last)
                    begin
                        $error("is_last: expected %0d, got %0d",
                               want.last, result_if.is_last);
                        error_count++;
                    end
                end
            end
        end
    end

    // The watchdog ends a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset once, hand the numbers to the driver, wait until
    // every number has been taken and every prediction has been matched,
    // then let the block settle.
    // ------------------------------------------------------------------------
    initial
    begin
        int k;
        int total_numbers;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        number_if.valid     = 1'b0;
        number_if.number_in = '0;
        result_if.ready     = 1'b0;

        fill_directed();
        for (k = 0; k < 76; k++)
            add_number(random_number(), $urandom_range(0, 19) == 0);
        total_numbers = pending_numbers.size();

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        while (accepted_count < total_numbers)
            @(negedge clk);
        while (expected_divisors.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
